// ===== src/hav_pkg.sv =====
// ----------------------------------------------------------------------------
// hav_pkg: shared types, constants and tables of the haversine distance block
// Fixed-point formats, the CORDIC arctangent table and the gain constants.
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int CORDIC_STEPS_DEF = 32;
  localparam int COORD_W  = 32;
  localparam int RADIUS_W = 23;
  localparam int DIST_W   = 25;
  localparam int ANG_W    = 36;   // Q32 radians, signed
  localparam int XY_W     = 34;   // CORDIC x and y, Q30, signed
  localparam int SC_W     = 32;   // clamped sine and cosine, Q30, signed
  localparam int SQ_W     = 61;   // Q60 operand of the square root
  localparam int SQ_STEPS = 31;   // one result bit per root cell
  localparam int ROOT_W   = 31;   // Q30 root
  localparam int C_W      = 35;   // central angle, Q32, unsigned

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;
  localparam logic signed [COORD_W-1:0] LAT_LIMIT = 32'sd900000000;
  localparam logic signed [COORD_W-1:0] LON_LIMIT = 32'sd1800000000;

  // pi in Q60, and the degree to radian factor pi * 2^64 / 1.8e9.
  localparam logic [63:0] PI60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] CONV_Q = PI60 / 64'd112500000;
  localparam logic [18:0] CONV_HI = 19'(CONV_Q >> 16);
  localparam logic [15:0] CONV_LO = 16'(CONV_Q);
  localparam logic signed [ANG_W-1:0] PI_Q32 = ANG_W'((PI60 + 64'd134217728) >> 28);
  localparam logic signed [ANG_W-1:0] HALF_PI = PI_Q32 >>> 1;
  localparam logic [63:0] ATAN_0 = ((PI60 >> 2) + 64'd134217728) >> 28;

  localparam logic signed [XY_W-1:0] ONE_Q30 = XY_W'(64'd1 << 30);
  localparam logic [SQ_W-1:0] ONE_Q60 = SQ_W'(64'd1 << 60);

  // Squared inverse gain in Q60 after each step of the rotation.
  localparam logic [63:0] K2_00 = 64'd1 << 59;
  localparam logic [63:0] K2_01 = K2_00 - K2_00 / ((64'd1 << 2) + 64'd1);
  localparam logic [63:0] K2_02 = K2_01 - K2_01 / ((64'd1 << 4) + 64'd1);
  localparam logic [63:0] K2_03 = K2_02 - K2_02 / ((64'd1 << 6) + 64'd1);
  localparam logic [63:0] K2_04 = K2_03 - K2_03 / ((64'd1 << 8) + 64'd1);
  localparam logic [63:0] K2_05 = K2_04 - K2_04 / ((64'd1 << 10) + 64'd1);
  localparam logic [63:0] K2_06 = K2_05 - K2_05 / ((64'd1 << 12) + 64'd1);
  localparam logic [63:0] K2_07 = K2_06 - K2_06 / ((64'd1 << 14) + 64'd1);
  localparam logic [63:0] K2_08 = K2_07 - K2_07 / ((64'd1 << 16) + 64'd1);
  localparam logic [63:0] K2_09 = K2_08 - K2_08 / ((64'd1 << 18) + 64'd1);
  localparam logic [63:0] K2_10 = K2_09 - K2_09 / ((64'd1 << 20) + 64'd1);
  localparam logic [63:0] K2_11 = K2_10 - K2_10 / ((64'd1 << 22) + 64'd1);
  localparam logic [63:0] K2_12 = K2_11 - K2_11 / ((64'd1 << 24) + 64'd1);
  localparam logic [63:0] K2_13 = K2_12 - K2_12 / ((64'd1 << 26) + 64'd1);
  localparam logic [63:0] K2_14 = K2_13 - K2_13 / ((64'd1 << 28) + 64'd1);
  localparam logic [63:0] K2_15 = K2_14 - K2_14 / ((64'd1 << 30) + 64'd1);
  localparam logic [63:0] K2_16 = K2_15 - K2_15 / ((64'd1 << 32) + 64'd1);
  localparam logic [63:0] K2_17 = K2_16 - K2_16 / ((64'd1 << 34) + 64'd1);
  localparam logic [63:0] K2_18 = K2_17 - K2_17 / ((64'd1 << 36) + 64'd1);
  localparam logic [63:0] K2_19 = K2_18 - K2_18 / ((64'd1 << 38) + 64'd1);
  localparam logic [63:0] K2_20 = K2_19 - K2_19 / ((64'd1 << 40) + 64'd1);
  localparam logic [63:0] K2_21 = K2_20 - K2_20 / ((64'd1 << 42) + 64'd1);
  localparam logic [63:0] K2_22 = K2_21 - K2_21 / ((64'd1 << 44) + 64'd1);
  localparam logic [63:0] K2_23 = K2_22 - K2_22 / ((64'd1 << 46) + 64'd1);
  localparam logic [63:0] K2_24 = K2_23 - K2_23 / ((64'd1 << 48) + 64'd1);
  localparam logic [63:0] K2_25 = K2_24 - K2_24 / ((64'd1 << 50) + 64'd1);
  localparam logic [63:0] K2_26 = K2_25 - K2_25 / ((64'd1 << 52) + 64'd1);
  localparam logic [63:0] K2_27 = K2_26 - K2_26 / ((64'd1 << 54) + 64'd1);
  localparam logic [63:0] K2_28 = K2_27 - K2_27 / ((64'd1 << 56) + 64'd1);
  localparam logic [63:0] K2_29 = K2_28 - K2_28 / ((64'd1 << 58) + 64'd1);
  localparam logic [63:0] K2_30 = K2_29 - K2_29 / ((64'd1 << 60) + 64'd1);
  localparam logic [63:0] K2_31 = K2_30 - K2_30 / ((64'd1 << 62) + 64'd1);

  localparam logic [63:0] K2_TAB [32] = '{
    K2_00, K2_01, K2_02, K2_03, K2_04, K2_05, K2_06, K2_07,
    K2_08, K2_09, K2_10, K2_11, K2_12, K2_13, K2_14, K2_15,
    K2_16, K2_17, K2_18, K2_19, K2_20, K2_21, K2_22, K2_23,
    K2_24, K2_25, K2_26, K2_27, K2_28, K2_29, K2_30, K2_31
  };

  typedef enum logic {CORDIC_ROTATE, CORDIC_VECTOR} cordic_mode_t;

  // Floor square root, evaluated only on constants.
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = n;
    res = '0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // atan(2^-i) in Q32, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_q32(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:       r = ANG_W'(ATAN_0);
      1:       r = 36'sd1991351318;
      2:       r = 36'sd1052175346;
      3:       r = 36'sd534100635;
      4:       r = 36'sd268086748;
      5:       r = 36'sd134174063;
      6:       r = 36'sd67103403;
      7:       r = 36'sd33553749;
      8:       r = 36'sd16777131;
      9:       r = 36'sd8388597;
      10:      r = 36'sd4194303;
      default: begin
        if (i <= 32) begin
          r = ANG_W'(64'd1 << (32 - i));
        end else if (i == 33) begin
          r = 36'sd1;
        end else begin
          r = '0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/hav_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// hav_cordic_cell: one CORDIC micro-rotation
// A registered step of either a rotation or a vectoring chain.
// ----------------------------------------------------------------------------
module hav_cordic_cell #(
  parameter hav_pkg::cordic_mode_t MODE = hav_pkg::CORDIC_ROTATE,
  parameter int STEP = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [hav_pkg::XY_W-1:0]   x_in,
  input  logic signed [hav_pkg::XY_W-1:0]   y_in,
  input  logic signed [hav_pkg::ANG_W-1:0]  z_in,
  output logic signed [hav_pkg::XY_W-1:0]   x,
  output logic signed [hav_pkg::XY_W-1:0]   y,
  output logic signed [hav_pkg::ANG_W-1:0]  z
);

  localparam logic signed [hav_pkg::ANG_W-1:0] ATAN = hav_pkg::atan_q32(STEP);

  logic signed [hav_pkg::XY_W-1:0] dx;
  logic signed [hav_pkg::XY_W-1:0] dy;
  logic                            sub;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;
  // Rotation steers by the residual angle, vectoring by the sign of y.
  assign sub = (MODE == hav_pkg::CORDIC_ROTATE) ? !z_in[hav_pkg::ANG_W-1]
                                                : y_in[hav_pkg::XY_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      x <= sub ? x_in - dx : x_in + dx;
      y <= sub ? y_in + dy : y_in - dy;
      z <= sub ? z_in - ATAN : z_in + ATAN;
    end
  end

endmodule

// ===== src/hav_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// hav_sqrt_cell: one step of the restoring integer square root
// Decides one result bit and passes remainder and partial root on.
// ----------------------------------------------------------------------------
module hav_sqrt_cell #(
  parameter int E = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hav_pkg::SQ_W-1:0]   n_in,
  input  logic [hav_pkg::SQ_W-1:0]   r_in,
  output logic [hav_pkg::SQ_W-1:0]   n,
  output logic [hav_pkg::SQ_W-1:0]   r
);

  localparam logic [hav_pkg::SQ_W:0] BIT = {{hav_pkg::SQ_W{1'b0}}, 1'b1} << E;

  logic [hav_pkg::SQ_W:0] trial;
  logic                   fits;

  assign trial = {1'b0, r_in} + BIT;
  assign fits  = {1'b0, n_in} >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      n <= fits ? n_in - trial[hav_pkg::SQ_W-1:0] : n_in;
      r <= fits ? (r_in >> 1) + BIT[hav_pkg::SQ_W-1:0] : r_in >> 1;
    end
  end

endmodule

// ===== src/haversine_distance.sv =====
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance between two GPS points
// Fully pipelined fixed-point haversine with CORDIC and root cell chains.
// ----------------------------------------------------------------------------
// The block takes one point pair per clock while it is not stalled and
// returns one distance per pair, in order, from the output register. The
// pipeline is made of the cell rows: four parallel rotation chains for the
// cosines and half-angle sines, two parallel 31-cell square root rows, one
// vectoring chain for the arctangent, and multiply and rounding stages.
// The pipeline stalls only when a result is held in the output register and
// the last stage is full. Coordinates are in 1e-7 degree; any latitude
// beyond 90 degrees or longitude beyond 180 degrees sets invalid and gives
// distance 0. The user must write the radius register via cfg_we / cfg_wdata
// only while no request is in flight; the block does not enforce this.
module haversine_distance #(
  parameter int CORDIC_STEPS = hav_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hav_pkg::RADIUS_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hav_pkg::COORD_W-1:0]  lat_a,
  input  logic signed [hav_pkg::COORD_W-1:0]  lon_a,
  input  logic signed [hav_pkg::COORD_W-1:0]  lat_b,
  input  logic signed [hav_pkg::COORD_W-1:0]  lon_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hav_pkg::DIST_W-1:0]          distance_m,
  output logic                                invalid
);

  localparam int L    = 12 + hav_pkg::SQ_STEPS + 2 * CORDIC_STEPS;
  localparam int GIDX = (CORDIC_STEPS - 1 > 31) ? 31 : CORDIC_STEPS - 1;
  localparam logic [63:0] GAIN = hav_pkg::isqrt64(hav_pkg::K2_TAB[GIDX]);

  function automatic logic signed [hav_pkg::SC_W-1:0] clamp_unit(
      input logic signed [hav_pkg::XY_W-1:0] v);
    logic signed [hav_pkg::XY_W-1:0] c;
    c = v;
    if (v > hav_pkg::ONE_Q30) begin
      c = hav_pkg::ONE_Q30;
    end else if (v < -hav_pkg::ONE_Q30) begin
      c = -hav_pkg::ONE_Q30;
    end
    return c[hav_pkg::SC_W-1:0];
  endfunction

  logic [hav_pkg::RADIUS_W-1:0] radius;
  logic                         adv;
  logic                         accept;
  logic                         bad;
  logic [L-1:0]                 vld;
  logic [L-1:0]                 inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= hav_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // The pipeline moves unless a held result would be overwritten.
  assign adv      = !out_valid || out_ready || !vld[L-1];
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  assign bad = (lat_a < -hav_pkg::LAT_LIMIT) || (lat_a > hav_pkg::LAT_LIMIT) ||
               (lat_b < -hav_pkg::LAT_LIMIT) || (lat_b > hav_pkg::LAT_LIMIT) ||
               (lon_a < -hav_pkg::LON_LIMIT) || (lon_a > hav_pkg::LON_LIMIT) ||
               (lon_b < -hav_pkg::LON_LIMIT) || (lon_b > hav_pkg::LON_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv <= {inv[L-2:0], bad};
    end
  end

  // Lanes: latitude a, latitude b, latitude difference, longitude difference.
  logic signed [hav_pkg::COORD_W:0]   raw [4];
  logic [hav_pkg::COORD_W-1:0]        s1_mag [4];
  logic [3:0]                         s1_neg;
  logic [50:0]                        s2_hi [4];
  logic [47:0]                        s2_lo [4];
  logic [3:0]                         s2_neg;
  logic [51:0]                        s3_p [4];
  logic [3:0]                         s3_neg;
  logic signed [hav_pkg::ANG_W-1:0]   s4_ang [4];
  logic signed [hav_pkg::ANG_W-1:0]   s5_ang [4];

  assign raw[0] = {lat_a[hav_pkg::COORD_W-1], lat_a};
  assign raw[1] = {lat_b[hav_pkg::COORD_W-1], lat_b};
  assign raw[2] = {lat_b[hav_pkg::COORD_W-1], lat_b} - {lat_a[hav_pkg::COORD_W-1], lat_a};
  assign raw[3] = {lon_b[hav_pkg::COORD_W-1], lon_b} - {lon_a[hav_pkg::COORD_W-1], lon_a};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        s1_neg[l] <= raw[l][hav_pkg::COORD_W];
        s1_mag[l] <= raw[l][hav_pkg::COORD_W] ? hav_pkg::COORD_W'(-raw[l])
                                              : hav_pkg::COORD_W'(raw[l]);
        s2_hi[l]  <= s1_mag[l] * hav_pkg::CONV_HI;
        s2_lo[l]  <= s1_mag[l] * hav_pkg::CONV_LO;
        s2_neg[l] <= s1_neg[l];
        s3_p[l]   <= {1'b0, s2_hi[l]} + 52'(s2_lo[l] >> 16);
        s3_neg[l] <= s2_neg[l];
      end
    end
  end

  logic [52:0]                      rsum [4];
  logic [hav_pkg::ANG_W-1:0]        rmag [4];

  // The half-angle lanes drop one more bit in the rounding shift.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (l < 2) begin
        rsum[l] = ({1'b0, s3_p[l]} + 53'h8000) >> 16;
      end else begin
        rsum[l] = ({1'b0, s3_p[l]} + 53'h10000) >> 17;
      end
      rmag[l] = rsum[l][hav_pkg::ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        s4_ang[l] <= s3_neg[l] ? -$signed(rmag[l]) : $signed(rmag[l]);
      end
      s5_ang[0] <= s4_ang[0];
      s5_ang[1] <= s4_ang[1];
      s5_ang[2] <= s4_ang[2];
      // Folding the half longitude by pi leaves its squared sine unchanged.
      if (s4_ang[3] > hav_pkg::HALF_PI) begin
        s5_ang[3] <= s4_ang[3] - hav_pkg::PI_Q32;
      end else if (s4_ang[3] < -hav_pkg::HALF_PI) begin
        s5_ang[3] <= s4_ang[3] + hav_pkg::PI_Q32;
      end else begin
        s5_ang[3] <= s4_ang[3];
      end
    end
  end

  logic signed [hav_pkg::XY_W-1:0]  rx [4][CORDIC_STEPS+1];
  logic signed [hav_pkg::XY_W-1:0]  ry [4][CORDIC_STEPS+1];
  logic signed [hav_pkg::ANG_W-1:0] rz [4][CORDIC_STEPS+1];

  for (genvar l = 0; l < 4; l++) begin : g_rot
    assign rx[l][0] = $signed(hav_pkg::XY_W'(GAIN));
    assign ry[l][0] = '0;
    assign rz[l][0] = s5_ang[l];
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      hav_cordic_cell #(
        .MODE (hav_pkg::CORDIC_ROTATE),
        .STEP (k)
      ) u_cell (
        .clk  (clk),
        .en   (adv),
        .x_in (rx[l][k]),
        .y_in (ry[l][k]),
        .z_in (rz[l][k]),
        .x    (rx[l][k+1]),
        .y    (ry[l][k+1]),
        .z    (rz[l][k+1])
      );
    end
  end

  logic signed [hav_pkg::SC_W-1:0]  m0_c1;
  logic signed [hav_pkg::SC_W-1:0]  m0_c2;
  logic signed [hav_pkg::SC_W-1:0]  m0_sh;
  logic signed [hav_pkg::SC_W-1:0]  m0_sl;
  logic signed [61:0]               m1_t1;
  logic signed [61:0]               m1_sq;
  logic signed [61:0]               m1_pc;
  logic signed [31:0]               cc;
  logic [hav_pkg::ROOT_W-1:0]       ss;
  logic [60:0]                      m2_t1;
  logic signed [63:0]               m2_t2;
  logic signed [63:0]               m3_sum;
  logic [hav_pkg::SQ_W-1:0]         m4_a;
  logic [hav_pkg::SQ_W-1:0]         m4_b;
  logic [hav_pkg::SQ_W-1:0]         a_clamp;

  assign cc = 32'(m1_pc >>> 30);
  assign ss = m1_sq[60:30];

  always_comb begin
    if (m3_sum < 0) begin
      a_clamp = '0;
    end else if (m3_sum > $signed({3'b000, hav_pkg::ONE_Q60})) begin
      a_clamp = hav_pkg::ONE_Q60;
    end else begin
      a_clamp = m3_sum[hav_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_c1  <= clamp_unit(rx[0][CORDIC_STEPS]);
      m0_c2  <= clamp_unit(rx[1][CORDIC_STEPS]);
      m0_sh  <= clamp_unit(ry[2][CORDIC_STEPS]);
      m0_sl  <= clamp_unit(ry[3][CORDIC_STEPS]);
      m1_t1  <= m0_sh * m0_sh;
      m1_sq  <= m0_sl * m0_sl;
      m1_pc  <= m0_c1 * m0_c2;
      m2_t1  <= m1_t1[60:0];
      m2_t2  <= cc * $signed({1'b0, ss});
      m3_sum <= $signed({3'b000, m2_t1}) + m2_t2;
      m4_a   <= a_clamp;
      m4_b   <= hav_pkg::ONE_Q60 - a_clamp;
    end
  end

  // Root row: lane 0 takes sqrt(a), lane 1 takes sqrt(1 - a).
  logic [hav_pkg::SQ_W-1:0] qn [2][hav_pkg::SQ_STEPS+1];
  logic [hav_pkg::SQ_W-1:0] qr [2][hav_pkg::SQ_STEPS+1];

  assign qn[0][0] = m4_a;
  assign qn[1][0] = m4_b;

  for (genvar l = 0; l < 2; l++) begin : g_root
    assign qr[l][0] = '0;
    for (genvar k = 0; k < hav_pkg::SQ_STEPS; k++) begin : g_cell
      hav_sqrt_cell #(
        .E (2 * (hav_pkg::SQ_STEPS - 1 - k))
      ) u_cell (
        .clk  (clk),
        .en   (adv),
        .n_in (qn[l][k]),
        .r_in (qr[l][k]),
        .n    (qn[l][k+1]),
        .r    (qr[l][k+1])
      );
    end
  end

  logic signed [hav_pkg::XY_W-1:0]  vx [CORDIC_STEPS+1];
  logic signed [hav_pkg::XY_W-1:0]  vy [CORDIC_STEPS+1];
  logic signed [hav_pkg::ANG_W-1:0] vz [CORDIC_STEPS+1];

  assign vx[0] = $signed({3'b000, qr[1][hav_pkg::SQ_STEPS][hav_pkg::ROOT_W-1:0]});
  assign vy[0] = $signed({3'b000, qr[0][hav_pkg::SQ_STEPS][hav_pkg::ROOT_W-1:0]});
  assign vz[0] = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    hav_cordic_cell #(
      .MODE (hav_pkg::CORDIC_VECTOR),
      .STEP (k)
    ) u_cell (
      .clk  (clk),
      .en   (adv),
      .x_in (vx[k]),
      .y_in (vy[k]),
      .z_in (vz[k]),
      .x    (vx[k+1]),
      .y    (vy[k+1]),
      .z    (vz[k+1])
    );
  end

  logic [hav_pkg::C_W-1:0]                 f1_c;
  logic [hav_pkg::C_W+hav_pkg::RADIUS_W-1:0] f2_prod;
  logic [hav_pkg::C_W+hav_pkg::RADIUS_W:0]   rounded;

  assign rounded = {1'b0, f2_prod} + (59'd1 << 31);

  always_ff @(posedge clk) begin
    if (adv) begin
      // The central angle is twice the arctangent, never below zero.
      f1_c    <= vz[CORDIC_STEPS][hav_pkg::ANG_W-1] ? '0
               : {vz[CORDIC_STEPS][hav_pkg::C_W-2:0], 1'b0};
      f2_prod <= radius * f1_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && vld[L-1]) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[L-1]) begin
      invalid    <= inv[L-1];
      distance_m <= inv[L-1] ? '0 : hav_pkg::DIST_W'(rounded >> 32);
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> distance_m == '0)
    else $error("invalid result carries a nonzero distance");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && vld[L-1])
    else $error("input stalled without a blocked output");

  a_enter_pipe: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_load_out: assert property (@(posedge clk) disable iff (rst)
    in_ready && vld[L-1] |=> out_valid)
    else $error("finished request was not moved to the output");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && vld == '0)
    else $error("pipeline not empty after reset");

endmodule
